### hdl/sbq_pkg.sv
// ---------------------------------------------------------------------------
// Broadcast queue package
// Sizes, codes and shared types of the multi-reader broadcast queue.
// ---------------------------------------------------------------------------
package sbq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int SUB_SLOTS     = 64;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int TAG_W         = 16;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 3;
   localparam int CAP_W         = 5;
   localparam int POS_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W        = $clog2(QUEUE_DEPTH);
   localparam int SUB_IDX_W     = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
   localparam int SUB_CNT_W     = 7;
   localparam int PEND_W        = 7;

   localparam logic [POS_W-1:0] NO_UNREAD = POS_W'(QUEUE_DEPTH);

   // operation codes
   localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 3'd1;
   localparam logic [OP_W-1:0] OP_PUT         = 3'd2;
   localparam logic [OP_W-1:0] OP_GET         = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT       = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECLAIM,
      S_SWEEP,
      S_FINISH,
      S_RESP
   } state_type;

   // per message cell control
   typedef struct packed {
      logic shift;
      logic load;
      logic dec;
   } msg_ctl_type;

   // one subscriber table entry
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [POS_W-1:0] mark;
   } sub_entry_type;

endpackage

### hdl/sbq_if.sv
// ---------------------------------------------------------------------------
// Broadcast queue channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sbq_req_if;
   logic                              valid;
   logic                              ready;
   logic [sbq_pkg::OP_W-1:0]          operation;
   logic [sbq_pkg::TAG_W-1:0]         subscriber_id;
   logic [sbq_pkg::PAYLOAD_WIDTH-1:0] payload;

   modport source (output valid, operation, subscriber_id, payload, input ready);
   modport sink   (input valid, operation, subscriber_id, payload, output ready);
endinterface

interface sbq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sbq_pkg::STATUS_W-1:0]      status;
   logic [sbq_pkg::PAYLOAD_WIDTH-1:0] message;
   logic [sbq_pkg::POS_W-1:0]         unread_count;

   modport source (output valid, status, message, unread_count, input ready);
   modport sink   (input valid, status, message, unread_count, output ready);
endinterface

### hdl/sbq_msg_cell.sv
// ---------------------------------------------------------------------------
// Message cell
// One queue position: word and pending reader count, shifts toward the head.
// ---------------------------------------------------------------------------
module sbq_msg_cell (
   input  logic                              clock,
   input  sbq_pkg::msg_ctl_type              ctl,
   input  logic [sbq_pkg::PAYLOAD_WIDTH-1:0] nb_word,
   input  logic [sbq_pkg::PEND_W-1:0]        nb_pend,
   input  logic [sbq_pkg::PAYLOAD_WIDTH-1:0] new_word,
   input  logic [sbq_pkg::PEND_W-1:0]        new_pend,
   output logic [sbq_pkg::PAYLOAD_WIDTH-1:0] word,
   output logic [sbq_pkg::PEND_W-1:0]        pend
);
   import sbq_pkg::*;

   logic [PAYLOAD_WIDTH-1:0] word_ff;
   logic [PEND_W-1:0]        pend_ff;

   // load a new message, take the neighbor's, or drop one reader
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         word_ff <= new_word;
         pend_ff <= new_pend;
      end else if (ctl.shift) begin
         word_ff <= nb_word;
         pend_ff <= nb_pend;
      end else if (ctl.dec && (pend_ff != '0)) begin
         pend_ff <= pend_ff - PEND_W'(1);
      end
   end

   assign word = word_ff;
   assign pend = pend_ff;

endmodule

### hdl/sbq_sub_cell.sv
// ---------------------------------------------------------------------------
// Subscriber cell
// One subscriber table entry in the circulating ring.
// ---------------------------------------------------------------------------
module sbq_sub_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  sbq_pkg::sub_entry_type nb,
   output sbq_pkg::sub_entry_type entry
);
   import sbq_pkg::*;

   sub_entry_type entry_ff;

   // clear valid on reset, advance the ring on shift
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (shift) begin
         entry_ff <= nb;
      end
   end

   assign entry = entry_ff;

endmodule

### hdl/broadcast_queue_with_reader_pointers.sv
// ---------------------------------------------------------------------------
// Broadcast queue with reader pointers
// Bounded queue read by every subscriber, each with its own next-unread mark.
// ---------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  req_bus  in         valid / ready    operation, subscriber_id, payload
//  rsp_bus  out        valid / ready    status, message, unread_count
//  csr      in         csr_wr_en        csr_wr_data (capacity)
//
//  A put that finds the queue full first reclaims head messages that no reader
//  still waits on (0..16 messages), until none is left to drop; every beat then
//  sweeps the subscriber ring and finishes before the response beat.
//  The subscriber ring makes one full turn per beat, one entry per cycle.
//  Reset clears the subscriber valid bits and the message count; no sweep.
//  req_bus stays low-ready until the response beat has been taken.
// ---------------------------------------------------------------------------
module broadcast_queue_with_reader_pointers (
   input  logic                       clock,
   input  logic                       reset,
   sbq_req_if.sink                    req_bus,
   sbq_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [sbq_pkg::CAP_W-1:0]  csr_wr_data
);
   import sbq_pkg::*;

   state_type state_ff, state_in;

   logic [OP_W-1:0]          op_ff;
   logic [TAG_W-1:0]         id_ff;
   logic [PAYLOAD_WIDTH-1:0] word_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [POS_W-1:0]         count_ff;
   logic [SUB_CNT_W-1:0]     sub_cnt_ff;
   logic [POS_W-1:0]         reclaim_ff;
   logic [SUB_IDX_W-1:0]     step_ff;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         rec_mark_ff, rec_mark_in;
   logic                     hit_ff, hit_in;
   logic [SLOT_W-1:0]        hit_pos_ff, hit_pos_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [PAYLOAD_WIDTH-1:0] message_ff;
   logic [POS_W-1:0]         unread_ff;

   logic [CAP_W-1:0]         cap_eff;
   logic                     put_ok;
   logic                     reclaim_go;
   logic                     accept;
   logic                     sub_shift;

   sub_entry_type            sub_q [SUB_SLOTS];
   sub_entry_type            head_new;
   logic [POS_W-1:0]         adj_mark;

   logic [PAYLOAD_WIDTH-1:0] mword_q [QUEUE_DEPTH];
   logic [PEND_W-1:0]        mpend_q [QUEUE_DEPTH];
   msg_ctl_type              mctl    [QUEUE_DEPTH];

   // effective capacity, clamped to 1..QUEUE_DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ff > CAP_W'(QUEUE_DEPTH)) begin
         cap_eff = CAP_W'(QUEUE_DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign put_ok     = ({1'b0, count_ff} < {1'b0, cap_eff}) && (sub_cnt_ff != '0);
   assign reclaim_go = (count_ff != '0) && (mpend_q[0] == '0);
   assign accept     = req_bus.valid && req_bus.ready;

   // subscriber ring
   for (genvar i = 0; i < SUB_SLOTS; i++) begin : g_sub
      sbq_sub_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (sub_shift),
         .nb    ((i == SUB_SLOTS - 1) ? head_new : sub_q[(i + 1) % SUB_SLOTS]),
         .entry (sub_q[i])
      );
   end

   // message chain
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_msg
      sbq_msg_cell u_cell (
         .clock    (clock),
         .ctl      (mctl[k]),
         .nb_word  ((k == QUEUE_DEPTH - 1) ? '0 : mword_q[(k + 1) % QUEUE_DEPTH]),
         .nb_pend  ((k == QUEUE_DEPTH - 1) ? '0 : mpend_q[(k + 1) % QUEUE_DEPTH]),
         .new_word (word_ff),
         .new_pend (PEND_W'(sub_cnt_ff)),
         .word     (mword_q[k]),
         .pend     (mpend_q[k])
      );
   end

   // find the oldest message that matches a remove word
   always_comb begin
      hit_in     = 1'b0;
      hit_pos_in = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (!hit_in && (POS_W'(k) < count_ff) && (mword_q[k] == req_bus.payload)) begin
            hit_in     = 1'b1;
            hit_pos_in = SLOT_W'(k);
         end
      end
   end

   // process the entry at the head of the ring
   always_comb begin
      head_new    = sub_q[0];
      found_in    = found_ff;
      rec_mark_in = rec_mark_ff;
      adj_mark    = sub_q[0].mark;
      case (op_ff)
         OP_SUBSCRIBE: begin
            if (!found_ff && !sub_q[0].valid) begin
               head_new.valid = 1'b1;
               head_new.tag   = id_ff;
               head_new.mark  = NO_UNREAD;
               found_in       = 1'b1;
            end
         end
         OP_UNSUBSCRIBE: begin
            if (!found_ff && sub_q[0].valid && (sub_q[0].tag == id_ff)) begin
               head_new.valid = 1'b0;
               head_new.mark  = NO_UNREAD;
               found_in       = 1'b1;
               rec_mark_in    = sub_q[0].mark;
            end
         end
         OP_PUT: begin
            if (sub_q[0].valid) begin
               if ((sub_q[0].mark != NO_UNREAD) && (reclaim_ff != '0)) begin
                  if (count_ff == '0) begin
                     adj_mark = NO_UNREAD;
                  end else if (sub_q[0].mark > reclaim_ff) begin
                     adj_mark = sub_q[0].mark - reclaim_ff;
                  end else begin
                     adj_mark = '0;
                  end
               end
               if (put_ok && (adj_mark == NO_UNREAD)) begin
                  adj_mark = count_ff;
               end
               head_new.mark = adj_mark;
            end
         end
         OP_GET: begin
            if (!found_ff && sub_q[0].valid && (sub_q[0].tag == id_ff)) begin
               found_in    = 1'b1;
               rec_mark_in = sub_q[0].mark;
               if (sub_q[0].mark < count_ff) begin
                  if ((sub_q[0].mark + POS_W'(1)) < count_ff) begin
                     head_new.mark = sub_q[0].mark + POS_W'(1);
                  end else begin
                     head_new.mark = NO_UNREAD;
                  end
               end
            end
         end
         OP_COUNT: begin
            if (!found_ff && sub_q[0].valid && (sub_q[0].tag == id_ff)) begin
               found_in    = 1'b1;
               rec_mark_in = sub_q[0].mark;
            end
         end
         OP_REMOVE: begin
            if (hit_ff && sub_q[0].valid && (sub_q[0].mark != NO_UNREAD)) begin
               if (sub_q[0].mark > {1'b0, hit_pos_ff}) begin
                  adj_mark = sub_q[0].mark - POS_W'(1);
               end
               if (adj_mark >= (count_ff - POS_W'(1))) begin
                  adj_mark = NO_UNREAD;
               end
               head_new.mark = adj_mark;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if ((req_bus.operation == OP_PUT) &&
                   ({1'b0, count_ff} >= {1'b0, cap_eff})) begin
                  state_in = S_RECLAIM;
               end else begin
                  state_in = S_SWEEP;
               end
            end
         end
         S_RECLAIM: begin
            if (!reclaim_go) begin
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (step_ff == SUB_IDX_W'(SUB_SLOTS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and message cell controls
   always_comb begin
      req_bus.ready = (state_ff == S_IDLE);
      rsp_bus.valid = (state_ff == S_RESP);
      sub_shift     = (state_ff == S_SWEEP);
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         mctl[k] = '0;
      end
      unique case (state_ff)
         S_RECLAIM: begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
               mctl[k].shift = reclaim_go;
            end
         end
         S_FINISH: begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
               case (op_ff)
                  OP_PUT: begin
                     mctl[k].load = put_ok && (count_ff == POS_W'(k));
                  end
                  OP_UNSUBSCRIBE: begin
                     mctl[k].dec = found_ff && (POS_W'(k) >= rec_mark_ff) &&
                                   (POS_W'(k) < count_ff);
                  end
                  OP_GET: begin
                     mctl[k].dec = found_ff && (rec_mark_ff < count_ff) &&
                                   (rec_mark_ff == POS_W'(k));
                  end
                  OP_REMOVE: begin
                     mctl[k].shift = hit_ff && (SLOT_W'(k) >= hit_pos_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.status       = status_ff;
   assign rsp_bus.message      = message_ff;
   assign rsp_bus.unread_count = unread_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cap_ff     <= CAP_W'(QUEUE_DEPTH);
         count_ff   <= '0;
         sub_cnt_ff <= '0;
         step_ff    <= '0;
         found_ff   <= 1'b0;
         reclaim_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               step_ff    <= '0;
               found_ff   <= 1'b0;
               reclaim_ff <= '0;
            end
            S_RECLAIM: begin
               if (reclaim_go) begin
                  count_ff   <= count_ff - POS_W'(1);
                  reclaim_ff <= reclaim_ff + POS_W'(1);
               end
            end
            S_SWEEP: begin
               step_ff  <= step_ff + SUB_IDX_W'(1);
               found_ff <= found_in;
            end
            S_FINISH: begin
               case (op_ff)
                  OP_SUBSCRIBE: begin
                     if (found_ff) begin
                        sub_cnt_ff <= sub_cnt_ff + SUB_CNT_W'(1);
                     end
                  end
                  OP_UNSUBSCRIBE: begin
                     if (found_ff && (sub_cnt_ff != '0)) begin
                        sub_cnt_ff <= sub_cnt_ff - SUB_CNT_W'(1);
                     end
                  end
                  OP_PUT: begin
                     if (put_ok) begin
                        count_ff <= count_ff + POS_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (hit_ff) begin
                        count_ff <= count_ff - POS_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // capture the request and the sweep findings
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_bus.operation;
         id_ff      <= req_bus.subscriber_id;
         word_ff    <= req_bus.payload;
         hit_ff     <= hit_in;
         hit_pos_ff <= hit_pos_in;
      end
      if (state_ff == S_SWEEP) begin
         rec_mark_ff <= rec_mark_in;
      end
   end

   // build the response beat
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH) begin
         status_ff  <= ST_OK;
         message_ff <= '0;
         unread_ff  <= '0;
         case (op_ff)
            OP_SUBSCRIBE, OP_UNSUBSCRIBE: begin
               if (!found_ff) begin
                  status_ff <= ST_UNKNOWN;
               end
            end
            OP_PUT: begin
               if ({1'b0, count_ff} >= {1'b0, cap_eff}) begin
                  status_ff <= ST_FULL;
               end else if (sub_cnt_ff == '0) begin
                  status_ff <= ST_DROPPED;
               end
            end
            OP_GET: begin
               if (!found_ff) begin
                  status_ff <= ST_UNKNOWN;
               end else if (rec_mark_ff >= count_ff) begin
                  status_ff <= ST_EMPTY;
               end else begin
                  message_ff <= mword_q[rec_mark_ff[SLOT_W-1:0]];
               end
            end
            OP_COUNT: begin
               if (!found_ff) begin
                  status_ff <= ST_UNKNOWN;
               end else if (rec_mark_ff < count_ff) begin
                  unread_ff <= count_ff - rec_mark_ff;
               end
            end
            OP_REMOVE: begin
               if (!hit_ff) begin
                  status_ff <= ST_NOT_FOUND;
               end
            end
            default: begin
               status_ff <= ST_UNKNOWN;
            end
         endcase
      end
   end

endmodule

### verif/broadcast_queue_with_reader_pointers_tb.sv
// ---------------------------------------------------------------------------
// Broadcast queue with reader pointers testbench
// Drives subscribe, unsubscribe, put, get, count and remove requests under
// several capacity settings with random idling on both channels, predicts
// every response with a behavioral queue model and compares field by field.
// ---------------------------------------------------------------------------
module broadcast_queue_with_reader_pointers_tb;
   import sbq_pkg::*;

   localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic [PAYLOAD_WIDTH-1:0] message;
      logic [POS_W-1:0]         unread;
   } outcome_type;

   // behavioral broadcast queue and store of pending responses
   class queue_scoreboard;
      logic [CAP_W-1:0]         cap_reg;
      logic [PAYLOAD_WIDTH-1:0] words[QUEUE_DEPTH];
      int                       readers[QUEUE_DEPTH];
      int                       order[QUEUE_DEPTH];
      int                       msg_cnt;
      logic [TAG_W-1:0]         tags[SUB_SLOTS];
      bit                       live[SUB_SLOTS];
      int                       mark[SUB_SLOTS];
      int                       sub_cnt;
      outcome_type              waiting[$];
      int                       errors;
      int                       checked;

      function void clear();
         cap_reg = 5'd16;
         msg_cnt = 0;
         sub_cnt = 0;
         errors = 0;
         checked = 0;
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            order[k] = k;
            readers[k] = 0;
            words[k] = '0;
         end
         for (int i = 0; i < SUB_SLOTS; i++) begin
            live[i] = 0;
            tags[i] = '0;
            mark[i] = QUEUE_DEPTH;
         end
      endfunction

      function int lookup(logic [TAG_W-1:0] id);
         for (int i = 0; i < SUB_SLOTS; i++)
            if (live[i] && tags[i] == id) return i;
         return -1;
      endfunction

      // take one queue position out of the order, fix reader marks
      function void take_out(int p);
         int s;
         if (p >= msg_cnt) return;
         s = order[p];
         for (int k = p; k + 1 < msg_cnt; k++) order[k] = order[k + 1];
         msg_cnt--;
         order[msg_cnt] = s;
         for (int i = 0; i < SUB_SLOTS; i++) begin
            if (!live[i] || mark[i] == QUEUE_DEPTH) continue;
            if (mark[i] > p) mark[i]--;
            if (mark[i] >= msg_cnt) mark[i] = QUEUE_DEPTH;
         end
      endfunction

      // advance the model by one accepted request beat
      function void note(logic [OP_W-1:0] op, logic [TAG_W-1:0] id,
                         logic [PAYLOAD_WIDTH-1:0] word);
         outcome_type o;
         int c, s, k, slot;
         o.status = ST_OK;
         o.message = '0;
         o.unread = '0;
         c = (cap_reg == 0) ? 1 : (cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg;
         case (op)
            OP_SUBSCRIBE: begin
               s = -1;
               for (int i = SUB_SLOTS - 1; i >= 0; i--) if (!live[i]) s = i;
               if (s < 0) o.status = ST_UNKNOWN;
               else begin
                  live[s] = 1;
                  tags[s] = id;
                  mark[s] = QUEUE_DEPTH;
                  sub_cnt++;
               end
            end
            OP_UNSUBSCRIBE: begin
               s = lookup(id);
               if (s < 0) o.status = ST_UNKNOWN;
               else begin
                  for (k = mark[s]; k < msg_cnt; k++)
                     if (readers[order[k]] > 0) readers[order[k]]--;
                  live[s] = 0;
                  mark[s] = QUEUE_DEPTH;
                  if (sub_cnt > 0) sub_cnt--;
               end
            end
            OP_PUT: begin
               if (msg_cnt >= c)
                  while (msg_cnt > 0 && readers[order[0]] == 0) take_out(0);
               if (msg_cnt >= c) o.status = ST_FULL;
               else if (sub_cnt == 0) o.status = ST_DROPPED;
               else begin
                  slot = order[msg_cnt];
                  words[slot] = word;
                  readers[slot] = sub_cnt & 'h7f;
                  for (int i = 0; i < SUB_SLOTS; i++)
                     if (live[i] && mark[i] == QUEUE_DEPTH) mark[i] = msg_cnt;
                  msg_cnt++;
               end
            end
            OP_GET: begin
               s = lookup(id);
               if (s < 0) o.status = ST_UNKNOWN;
               else if (mark[s] >= msg_cnt) o.status = ST_EMPTY;
               else begin
                  k = mark[s];
                  slot = order[k];
                  o.message = words[slot];
                  if (readers[slot] > 0) readers[slot]--;
                  mark[s] = (k + 1 < msg_cnt) ? k + 1 : QUEUE_DEPTH;
               end
            end
            OP_COUNT: begin
               s = lookup(id);
               if (s < 0) o.status = ST_UNKNOWN;
               else if (mark[s] < msg_cnt) o.unread = POS_W'(msg_cnt - mark[s]);
            end
            OP_REMOVE: begin
               k = 0;
               while (k < msg_cnt && words[order[k]] != word) k++;
               if (k == msg_cnt) o.status = ST_NOT_FOUND;
               else take_out(k);
            end
            default: o.status = ST_UNKNOWN;
         endcase
         waiting.push_back(o);
      endfunction

      // compare one response beat with the oldest prediction
      function void check(logic [STATUS_W-1:0] st, logic [PAYLOAD_WIDTH-1:0] msg,
                          logic [POS_W-1:0] unr);
         outcome_type o;
         if (waiting.size() == 0) begin
            $display("%0t: unexpected response status=%0d message=%h unread=%0d",
                     $time, st, msg, unr);
            errors++;
            return;
         end
         o = waiting.pop_front();
         checked++;
         if (st !== o.status) begin
            $display("%0t: status expected %0d actual %0d", $time, o.status, st);
            errors++;
         end
         if (msg !== o.message) begin
            $display("%0t: message expected %h actual %h", $time, o.message, msg);
            errors++;
         end
         if (unr !== o.unread) begin
            $display("%0t: unread_count expected %0d actual %0d", $time, o.unread, unr);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;
   sbq_req_if req_bus();
   sbq_rsp_if rsp_bus();

   broadcast_queue_with_reader_pointers dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   queue_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int cycles = 0;
   int sent;
   logic [TAG_W-1:0] tag_pool[8];
   logic [PAYLOAD_WIDTH-1:0] word_pool[12];

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  board.waiting.size());
         $display("broadcast_queue_with_reader_pointers test failed");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check(rsp_bus.status, rsp_bus.message, rsp_bus.unread_count);
   end

   // drive one request beat; valid stays up into the next beat unless a gap follows
   task automatic send(logic [OP_W-1:0] op, logic [TAG_W-1:0] id,
                       logic [PAYLOAD_WIDTH-1:0] word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.subscriber_id <= id;
      req_bus.payload <= word;
      do @(posedge clock); while (!req_bus.ready);
      board.note(op, id, word);
      sent++;
      // set idling per phase of the run
      if (sent == 300) begin
         send_idle_pct = 52;
         recv_idle_pct = 24;
      end else if (sent == 600) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // write capacity once the block has drained
   task automatic write_capacity(logic [CAP_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (board.waiting.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.cap_reg = value;
   endtask

   function automatic logic [TAG_W-1:0] pick_tag();
      return ($urandom_range(9) < 8) ? tag_pool[$urandom_range(7)] : TAG_W'($urandom);
   endfunction

   function automatic logic [PAYLOAD_WIDTH-1:0] pick_word();
      return ($urandom_range(9) < 6) ? word_pool[$urandom_range(11)] : $urandom;
   endfunction

   task automatic random_items(int n);
      int r;
      logic [OP_W-1:0] op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 14)      op = OP_SUBSCRIBE;
         else if (r < 22) op = OP_UNSUBSCRIBE;
         else if (r < 50) op = OP_PUT;
         else if (r < 76) op = OP_GET;
         else if (r < 86) op = OP_COUNT;
         else if (r < 97) op = OP_REMOVE;
         else             op = (r < 98) ? OP_BAD_LO : OP_BAD_HI;
         send(op, pick_tag(), pick_word());
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = '0;
      req_bus.subscriber_id = '0;
      req_bus.payload = '0;
      sent = 0;
      send_idle_pct = 24;
      recv_idle_pct = 52;
      board = new();
      board.clear();
      tag_pool = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h5555, 16'haaaa,
                   16'h0042, 16'h7fff};
      word_pool = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000, 32'h55555555,
                    32'haaaaaaaa, 32'h12345678, 32'h7fffffff, 32'h2, 32'h3,
                    32'hdeadbeef, 32'h0000ffff};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and corner cases
      send(OP_SUBSCRIBE, 16'h0000, 32'h0);
      send(OP_SUBSCRIBE, 16'hffff, 32'h0);
      send(OP_COUNT, 16'hffff, 32'h0);
      send(OP_GET, 16'h0000, 32'h0);
      send(OP_PUT, 16'h0000, 32'hffffffff);
      send(OP_PUT, 16'hffff, 32'h0);
      send(OP_COUNT, 16'h0000, 32'h0);
      send(OP_GET, 16'h0000, 32'h0);
      send(OP_REMOVE, 16'h0000, 32'h0);
      send(OP_REMOVE, 16'h0000, 32'h12345);
      send(OP_GET, 16'h1234, 32'h0);
      send(OP_UNSUBSCRIBE, 16'h1234, 32'h0);
      send(OP_COUNT, 16'h1234, 32'h0);
      send(OP_BAD_LO, 16'h0000, 32'hffffffff);
      send(OP_BAD_HI, 16'hffff, 32'h0);
      send(OP_SUBSCRIBE, 16'h0000, 32'h0);
      send(OP_UNSUBSCRIBE, 16'hffff, 32'h0);
      send(OP_UNSUBSCRIBE, 16'h0000, 32'h0);
      send(OP_UNSUBSCRIBE, 16'h0000, 32'h0);
      send(OP_PUT, 16'h0000, 32'ha5a5a5a5);
      send(OP_SUBSCRIBE, 16'h0001, 32'h0);
      send(OP_GET, 16'h0001, 32'h0);

      // tight capacity: reclaim and full retries
      write_capacity(5'd1);
      random_items(120);
      write_capacity(5'd0);
      random_items(80);

      // fill the subscriber table past its end, then unsubscribe random tags
      write_capacity(5'd31);
      for (int i = 0; i < SUB_SLOTS + 3; i++) send(OP_SUBSCRIBE, pick_tag(), 32'h0);
      send(OP_PUT, 16'h0, 32'hffffffff);
      for (int i = 0; i < SUB_SLOTS + 6; i++) send(OP_UNSUBSCRIBE, pick_tag(), 32'h0);
      random_items(150);

      write_capacity(5'd3);
      random_items(150);
      write_capacity(5'd16);
      random_items(260);

      // drain
      req_bus.valid <= 1'b0;
      while (board.waiting.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests, checked %0d responses over capacities 1, 0, 31, 3, 16",
               sent, board.checked);
      $display("including table overflow, reclaim, drops and remove by payload");
      if (board.errors == 0 && board.waiting.size() == 0) begin
         $display("broadcast_queue_with_reader_pointers test passed");
      end else begin
         $display("broadcast_queue_with_reader_pointers test failed");
      end
      $finish;
   end
endmodule
